// ===== rtl/clfl_pkg.sv =====
// Shared types and constants of the cursor list block.
`timescale 1ns / 1ps
package clfl_pkg;

   localparam int KEY_W = 64;
   localparam int ID_W  = 15;
   localparam int PAY_W = 32;
   localparam int REC_W = KEY_W + ID_W + PAY_W;

   localparam logic signed [ID_W-1:0] NO_ID = -15'sd999;
   localparam logic [6:0] COUNT_MAX = 7'd127;

   typedef enum logic [2:0] {
      ACT_INSERT    = 3'd0,
      ACT_DEL_FIRST = 3'd1,
      ACT_DEL_ALL   = 3'd2,
      ACT_COPY      = 3'd3,
      ACT_READ      = 3'd4,
      ACT_CLEAR     = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_HEAP_FULL = 2'd2,
      ST_BAD       = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_INS_WR, S_DEL_LOOP, S_DEL_EVAL, S_DEL_FREE,
      S_CPY_LOOP, S_CPY_LATCH, S_CPY_SCAN, S_CPY_STEP, S_CPY_TAKE, S_CPY_ALLOC,
      S_CPY_LINK, S_CPY_RDNEXT, S_CPY_ADV, S_RD_DATA, S_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_SET_FULL, OP_SET_BAD, OP_TAKE_RD, OP_INS_WR,
      OP_DEL_INIT, OP_CUR_RD, OP_DEL_EVAL, OP_DEL_FREE, OP_CPY_INIT, OP_CPY_LATCH,
      OP_P_RD, OP_P_ADV, OP_CPY_SKIP, OP_CPY_ALLOC, OP_CPY_LINK, OP_CUR_RD_LINK,
      OP_CPY_ADV, OP_RD_NODE, OP_RD_OUT, OP_CLEAR, OP_FIN
   } op_type;

   typedef struct packed {
      action_type act;
      logic       same_list;
      logic       sel_ok;
      logic       free_ok;
      logic       cur_ok;
      logic       p_ok;
      logic       match;
      logic       less;
      logic       prev_null;
   } dp_status_type;

endpackage

// ===== rtl/clfl_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module clfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/clfl_ctrl.sv =====
// Controller state machine of the cursor list block.
`timescale 1ns / 1ps
module clfl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  clfl_pkg::dp_status_type stat,
   output clfl_pkg::op_type        op
);
   clfl_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != clfl_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clfl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op           = clfl_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         clfl_pkg::S_IDLE: begin
            if (req_valid) begin
               op       = clfl_pkg::OP_LOAD;
               state_in = clfl_pkg::S_DISPATCH;
            end
         end
         clfl_pkg::S_DISPATCH: begin
            state_in = clfl_pkg::S_FIN;
            unique case (stat.act) inside
               clfl_pkg::ACT_INSERT: begin
                  if (stat.free_ok) begin
                     op       = clfl_pkg::OP_TAKE_RD;
                     state_in = clfl_pkg::S_INS_WR;
                  end else begin
                     op = clfl_pkg::OP_SET_FULL;
                  end
               end
               clfl_pkg::ACT_DEL_FIRST, clfl_pkg::ACT_DEL_ALL: begin
                  op       = clfl_pkg::OP_DEL_INIT;
                  state_in = clfl_pkg::S_DEL_LOOP;
               end
               clfl_pkg::ACT_COPY: begin
                  if (stat.same_list) begin
                     op = clfl_pkg::OP_SET_BAD;
                  end else begin
                     op       = clfl_pkg::OP_CPY_INIT;
                     state_in = clfl_pkg::S_CPY_LOOP;
                  end
               end
               clfl_pkg::ACT_READ: begin
                  if (stat.sel_ok) begin
                     op       = clfl_pkg::OP_RD_NODE;
                     state_in = clfl_pkg::S_RD_DATA;
                  end else begin
                     op = clfl_pkg::OP_SET_BAD;
                  end
               end
               clfl_pkg::ACT_CLEAR: op = clfl_pkg::OP_CLEAR;
               default:             op = clfl_pkg::OP_SET_BAD;
            endcase
         end
         clfl_pkg::S_INS_WR: begin
            op       = clfl_pkg::OP_INS_WR;
            state_in = clfl_pkg::S_FIN;
         end
         clfl_pkg::S_DEL_LOOP: begin
            if (stat.cur_ok) begin
               op       = clfl_pkg::OP_CUR_RD;
               state_in = clfl_pkg::S_DEL_EVAL;
            end else begin
               state_in = clfl_pkg::S_FIN;
            end
         end
         clfl_pkg::S_DEL_EVAL: begin
            op       = clfl_pkg::OP_DEL_EVAL;
            state_in = stat.match ? clfl_pkg::S_DEL_FREE : clfl_pkg::S_DEL_LOOP;
         end
         clfl_pkg::S_DEL_FREE: begin
            op       = clfl_pkg::OP_DEL_FREE;
            state_in = (stat.act == clfl_pkg::ACT_DEL_ALL) ? clfl_pkg::S_DEL_LOOP
                                                           : clfl_pkg::S_FIN;
         end
         clfl_pkg::S_CPY_LOOP: begin
            if (stat.cur_ok) begin
               op       = clfl_pkg::OP_CUR_RD;
               state_in = clfl_pkg::S_CPY_LATCH;
            end else begin
               state_in = clfl_pkg::S_FIN;
            end
         end
         clfl_pkg::S_CPY_LATCH: begin
            op       = clfl_pkg::OP_CPY_LATCH;
            state_in = clfl_pkg::S_CPY_SCAN;
         end
         clfl_pkg::S_CPY_SCAN: begin
            if (stat.p_ok) begin
               op       = clfl_pkg::OP_P_RD;
               state_in = clfl_pkg::S_CPY_STEP;
            end else begin
               state_in = clfl_pkg::S_CPY_TAKE;
            end
         end
         clfl_pkg::S_CPY_STEP: begin
            if (stat.less) begin
               op       = clfl_pkg::OP_P_ADV;
               state_in = clfl_pkg::S_CPY_SCAN;
            end else begin
               state_in = clfl_pkg::S_CPY_TAKE;
            end
         end
         clfl_pkg::S_CPY_TAKE: begin
            if (stat.free_ok) begin
               op       = clfl_pkg::OP_TAKE_RD;
               state_in = clfl_pkg::S_CPY_ALLOC;
            end else begin
               op       = clfl_pkg::OP_CPY_SKIP;
               state_in = clfl_pkg::S_CPY_RDNEXT;
            end
         end
         clfl_pkg::S_CPY_ALLOC: begin
            op       = clfl_pkg::OP_CPY_ALLOC;
            state_in = stat.prev_null ? clfl_pkg::S_CPY_RDNEXT : clfl_pkg::S_CPY_LINK;
         end
         clfl_pkg::S_CPY_LINK: begin
            op       = clfl_pkg::OP_CPY_LINK;
            state_in = clfl_pkg::S_CPY_RDNEXT;
         end
         clfl_pkg::S_CPY_RDNEXT: begin
            op       = clfl_pkg::OP_CUR_RD_LINK;
            state_in = clfl_pkg::S_CPY_ADV;
         end
         clfl_pkg::S_CPY_ADV: begin
            op       = clfl_pkg::OP_CPY_ADV;
            state_in = clfl_pkg::S_CPY_LOOP;
         end
         clfl_pkg::S_RD_DATA: begin
            op       = clfl_pkg::OP_RD_OUT;
            state_in = clfl_pkg::S_FIN;
         end
         clfl_pkg::S_FIN: begin
            if (out_free) begin
               op           = clfl_pkg::OP_FIN;
               rsp_valid_in = 1'b1;
               state_in     = clfl_pkg::S_IDLE;
            end
         end
         default: state_in = clfl_pkg::S_IDLE;
      endcase
   end
endmodule

// ===== rtl/clfl_dp.sv =====
// Datapath of the cursor list block: node stores, heads, walk registers.
`timescale 1ns / 1ps
module clfl_dp #(
   parameter int ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  clfl_pkg::op_type        op,
   output clfl_pkg::dp_status_type stat,
   input  logic [2:0]              req_action,
   input  logic                    req_list_sel,
   input  logic                    req_dest_list,
   input  logic [63:0]             req_match_key,
   input  logic [13:0]             req_sort_key,
   input  logic [31:0]             req_payload,
   input  logic [5:0]              req_node_sel,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_match_count,
   output logic signed [6:0]       rsp_node_index,
   output logic [63:0]             rsp_read_key,
   output logic signed [14:0]      rsp_read_sort_key,
   output logic [31:0]             rsp_read_payload,
   output logic signed [6:0]       rsp_read_link,
   output logic signed [6:0]       rsp_list_head,
   output logic signed [6:0]       rsp_free_top
);
   localparam int IW = $clog2(ENTRIES);
   localparam int LW = IW + 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic signed [LW-1:0] END_LINK = -1;
   localparam logic signed [LW-1:0] UNLINKED = -2;
   localparam logic [CW-1:0] WALK_MAX = CW'(ENTRIES);

   // control state
   logic signed [LW-1:0] heads_ff [2];
   logic signed [LW-1:0] heads_in [2];
   logic signed [LW-1:0] free_ff, free_in;
   logic [CW-1:0]        fresh_ff, fresh_in;
   // request and walk registers
   clfl_pkg::action_type act_ff, act_in;
   logic                 lst_ff, lst_in, dst_ff, dst_in;
   logic [63:0]          key_ff, key_in;
   logic [13:0]          id_ff, id_in;
   logic [31:0]          pay_ff, pay_in;
   logic [5:0]           sel_ff, sel_in;
   logic signed [LW-1:0] cur_ff, cur_in, prev_ff, prev_in, p_ff, p_in, nreg_ff, nreg_in;
   logic [CW-1:0]        steps_ff, steps_in, inner_ff, inner_in;
   logic [6:0]           cnt_ff, cnt_in;
   clfl_pkg::status_type res_st_ff, res_st_in;
   logic signed [LW-1:0] node_ff, node_in, rlink_ff, rlink_in;
   logic [63:0]          rkey_ff, rkey_in, ck_ff, ck_in;
   logic signed [14:0]   rid_ff, rid_in, cid_ff, cid_in;
   logic [31:0]          rpay_ff, rpay_in, cdat_ff, cdat_in;
   logic [IW-1:0]        rd_q_ff;
   // result registers
   logic [1:0]           o_st_ff, o_st_in;
   logic [6:0]           o_cnt_ff, o_cnt_in;
   logic signed [6:0]    o_node_ff, o_node_in, o_link_ff, o_link_in;
   logic signed [6:0]    o_head_ff, o_head_in, o_free_ff, o_free_in;
   logic [63:0]          o_key_ff, o_key_in;
   logic signed [14:0]   o_id_ff, o_id_in;
   logic [31:0]          o_pay_ff, o_pay_in;

   // memory ports
   logic [IW-1:0]               rd_addr, link_wa, rec_wa;
   logic                        link_we, rec_we;
   logic [LW-1:0]               link_wd, link_q;
   logic [clfl_pkg::REC_W-1:0]  rec_wd, rec_q;

   logic                 fresh_hit;
   logic signed [LW-1:0] seq_val, link_val;
   logic [63:0]          rec_key;
   logic signed [14:0]   rec_id;
   logic [31:0]          rec_pay;
   logic [CW-1:0]        take_idx;
   logic [6:0]           cnt_inc;

   clfl_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(rd_addr), .rd_data(link_q)
   );

   clfl_ram #(.WIDTH(clfl_pkg::REC_W), .DEPTH(ENTRIES)) u_rec_ram (
      .clock(clock), .wr_en(rec_we), .wr_addr(rec_wa), .wr_data(rec_wd),
      .rd_addr(rd_addr), .rd_data(rec_q)
   );

   // nodes below the fresh mark were never taken: link i-1 and no ID
   assign fresh_hit = CW'(rd_q_ff) < fresh_ff;
   assign seq_val   = $signed({1'b0, rd_q_ff}) - $signed(LW'(1));
   assign link_val  = fresh_hit ? seq_val : $signed(link_q);
   assign rec_key   = rec_q[clfl_pkg::REC_W-1 -: 64];
   assign rec_id    = fresh_hit ? clfl_pkg::NO_ID : $signed(rec_q[46:32]);
   assign rec_pay   = rec_q[31:0];
   assign take_idx  = CW'(free_ff[IW-1:0]);
   assign cnt_inc   = (cnt_ff == clfl_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 7'd1;

   assign stat.act       = act_ff;
   assign stat.same_list = (lst_ff == dst_ff);
   assign stat.sel_ok    = (32'(sel_ff) < 32'(ENTRIES));
   assign stat.free_ok   = !free_ff[LW-1];
   assign stat.cur_ok    = !cur_ff[LW-1] && (steps_ff != WALK_MAX);
   assign stat.p_ok      = !p_ff[LW-1] && (inner_ff != WALK_MAX);
   assign stat.match     = (rec_key == key_ff);
   assign stat.less      = (rec_id < cid_ff);
   assign stat.prev_null = prev_ff[LW-1];

   always_comb begin
      heads_in  = heads_ff;
      free_in   = free_ff;
      fresh_in  = fresh_ff;
      act_in    = act_ff;
      lst_in    = lst_ff;
      dst_in    = dst_ff;
      key_in    = key_ff;
      id_in     = id_ff;
      pay_in    = pay_ff;
      sel_in    = sel_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      p_in      = p_ff;
      nreg_in   = nreg_ff;
      steps_in  = steps_ff;
      inner_in  = inner_ff;
      cnt_in    = cnt_ff;
      res_st_in = res_st_ff;
      node_in   = node_ff;
      rlink_in  = rlink_ff;
      rkey_in   = rkey_ff;
      rid_in    = rid_ff;
      rpay_in   = rpay_ff;
      ck_in     = ck_ff;
      cid_in    = cid_ff;
      cdat_in   = cdat_ff;
      o_st_in   = o_st_ff;
      o_cnt_in  = o_cnt_ff;
      o_node_in = o_node_ff;
      o_link_in = o_link_ff;
      o_head_in = o_head_ff;
      o_free_in = o_free_ff;
      o_key_in  = o_key_ff;
      o_id_in   = o_id_ff;
      o_pay_in  = o_pay_ff;
      rd_addr   = cur_ff[IW-1:0];
      link_we   = 1'b0;
      link_wa   = free_ff[IW-1:0];
      link_wd   = UNLINKED;
      rec_we    = 1'b0;
      rec_wa    = free_ff[IW-1:0];
      rec_wd    = {ck_ff, cid_ff, cdat_ff};
      unique case (op)
         clfl_pkg::OP_NONE: ;
         clfl_pkg::OP_LOAD: begin
            act_in    = clfl_pkg::action_type'(req_action);
            lst_in    = req_list_sel;
            dst_in    = req_dest_list;
            key_in    = req_match_key;
            id_in     = req_sort_key;
            pay_in    = req_payload;
            sel_in    = req_node_sel;
            cnt_in    = '0;
            res_st_in = clfl_pkg::ST_OK;
            node_in   = END_LINK;
            rlink_in  = '0;
            rkey_in   = '0;
            rid_in    = '0;
            rpay_in   = '0;
         end
         clfl_pkg::OP_SET_FULL: res_st_in = clfl_pkg::ST_HEAP_FULL;
         clfl_pkg::OP_SET_BAD:  res_st_in = clfl_pkg::ST_BAD;
         clfl_pkg::OP_TAKE_RD:  rd_addr = free_ff[IW-1:0];
         clfl_pkg::OP_INS_WR: begin
            free_in          = link_val;
            fresh_in         = (take_idx < fresh_ff) ? take_idx : fresh_ff;
            link_we          = 1'b1;
            link_wd          = heads_ff[lst_ff];
            rec_we           = 1'b1;
            rec_wd           = {key_ff, {1'b0, id_ff}, pay_ff};
            heads_in[lst_ff] = free_ff;
            node_in          = free_ff;
         end
         clfl_pkg::OP_DEL_INIT: begin
            prev_in  = END_LINK;
            cur_in   = heads_ff[lst_ff];
            steps_in = '0;
         end
         clfl_pkg::OP_CUR_RD: begin
            rd_addr  = cur_ff[IW-1:0];
            steps_in = steps_ff + CW'(1);
         end
         clfl_pkg::OP_DEL_EVAL: begin
            if (rec_key == key_ff) begin
               if (prev_ff[LW-1]) begin
                  heads_in[lst_ff] = link_val;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff[IW-1:0];
                  link_wd = link_val;
               end
               nreg_in = cur_ff;
               cnt_in  = cnt_inc;
            end else begin
               prev_in = cur_ff;
            end
            cur_in = link_val;
         end
         clfl_pkg::OP_DEL_FREE: begin
            link_we = 1'b1;
            link_wa = nreg_ff[IW-1:0];
            link_wd = free_ff;
            free_in = nreg_ff;
         end
         clfl_pkg::OP_CPY_INIT: begin
            cur_in   = heads_ff[lst_ff];
            steps_in = '0;
         end
         clfl_pkg::OP_CPY_LATCH: begin
            ck_in    = rec_key;
            cid_in   = rec_id;
            cdat_in  = rec_pay;
            prev_in  = END_LINK;
            p_in     = heads_ff[dst_ff];
            inner_in = '0;
         end
         clfl_pkg::OP_P_RD: rd_addr = p_ff[IW-1:0];
         clfl_pkg::OP_P_ADV: begin
            prev_in  = p_ff;
            p_in     = link_val;
            inner_in = inner_ff + CW'(1);
         end
         clfl_pkg::OP_CPY_SKIP: res_st_in = clfl_pkg::ST_HEAP_FULL;
         clfl_pkg::OP_CPY_ALLOC: begin
            free_in  = link_val;
            fresh_in = (take_idx < fresh_ff) ? take_idx : fresh_ff;
            link_we  = 1'b1;
            link_wd  = p_ff;
            rec_we   = 1'b1;
            cnt_in   = cnt_inc;
            nreg_in  = free_ff;
            if (prev_ff[LW-1]) begin
               heads_in[dst_ff] = free_ff;
            end
         end
         clfl_pkg::OP_CPY_LINK: begin
            link_we = 1'b1;
            link_wa = prev_ff[IW-1:0];
            link_wd = nreg_ff;
         end
         clfl_pkg::OP_CUR_RD_LINK: rd_addr = cur_ff[IW-1:0];
         clfl_pkg::OP_CPY_ADV:     cur_in = link_val;
         clfl_pkg::OP_RD_NODE:     rd_addr = IW'(sel_ff);
         clfl_pkg::OP_RD_OUT: begin
            rkey_in  = rec_key;
            rid_in   = rec_id;
            rpay_in  = rec_pay;
            rlink_in = link_val;
         end
         clfl_pkg::OP_CLEAR: heads_in[lst_ff] = END_LINK;
         clfl_pkg::OP_FIN: begin
            if (act_ff == clfl_pkg::ACT_DEL_FIRST) begin
               o_cnt_in = '0;
               o_st_in  = (cnt_ff == 7'd0) ? clfl_pkg::ST_NOT_FOUND : res_st_ff;
            end else begin
               o_cnt_in = cnt_ff;
               o_st_in  = res_st_ff;
            end
            o_node_in = 7'(node_ff);
            o_link_in = 7'(rlink_ff);
            o_head_in = 7'(heads_ff[lst_ff]);
            o_free_in = 7'(free_ff);
            o_key_in  = rkey_ff;
            o_id_in   = rid_ff;
            o_pay_in  = rpay_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heads_ff[0] <= END_LINK;
         heads_ff[1] <= END_LINK;
         free_ff     <= LW'(ENTRIES - 1);
         fresh_ff    <= WALK_MAX;
      end else begin
         heads_ff <= heads_in;
         free_ff  <= free_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      lst_ff    <= lst_in;
      dst_ff    <= dst_in;
      key_ff    <= key_in;
      id_ff     <= id_in;
      pay_ff    <= pay_in;
      sel_ff    <= sel_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      p_ff      <= p_in;
      nreg_ff   <= nreg_in;
      steps_ff  <= steps_in;
      inner_ff  <= inner_in;
      cnt_ff    <= cnt_in;
      res_st_ff <= res_st_in;
      node_ff   <= node_in;
      rlink_ff  <= rlink_in;
      rkey_ff   <= rkey_in;
      rid_ff    <= rid_in;
      rpay_ff   <= rpay_in;
      ck_ff     <= ck_in;
      cid_ff    <= cid_in;
      cdat_ff   <= cdat_in;
      rd_q_ff   <= rd_addr;
      o_st_ff   <= o_st_in;
      o_cnt_ff  <= o_cnt_in;
      o_node_ff <= o_node_in;
      o_link_ff <= o_link_in;
      o_head_ff <= o_head_in;
      o_free_ff <= o_free_in;
      o_key_ff  <= o_key_in;
      o_id_ff   <= o_id_in;
      o_pay_ff  <= o_pay_in;
   end

   assign rsp_status        = o_st_ff;
   assign rsp_match_count   = o_cnt_ff;
   assign rsp_node_index    = o_node_ff;
   assign rsp_read_key      = o_key_ff;
   assign rsp_read_sort_key = o_id_ff;
   assign rsp_read_payload  = o_pay_ff;
   assign rsp_read_link     = o_link_ff;
   assign rsp_list_head     = o_head_ff;
   assign rsp_free_top      = o_free_ff;
endmodule

// ===== rtl/cursor_list_with_free_list.sv =====
// Top level of the cursor list with free list: controller, datapath, checks.
`timescale 1ns / 1ps
// Two linked lists and a free list share one node store of ENTRIES records.
// Request channel (req_*): one beat carries an action and its operands; it is
// taken when req_valid is high and req_stall low. Response channel (rsp_*):
// exactly one beat per request, in request order, held while rsp_stall is high.
// One request is worked on at a time; req_stall stays high from the accepted
// beat until its response has been loaded into the output register. A new
// request may be taken while that response still waits on a stalled receiver.
// The node store read port gives one read per cycle, data in the next cycle.
// Insert and read each access one node; clear and rejected requests need no
// node access. Deletes read every node walked and free every match; a
// delete_first stops at its match. Sorted copy reads each source node, then
// compares destination nodes until one has a sort key not below its own or
// the scan runs off the end, takes a free node if there is one, and links it
// mid-list when it does not go at the head.
// Reset leaves both heads empty and the free list top at ENTRIES-1; the
// never-used nodes are tracked by a low-water mark instead of a clearing pass.
module cursor_list_with_free_list #(
   parameter int ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic               req_list_sel,
   input  logic               req_dest_list,
   input  logic [63:0]        req_match_key,
   input  logic [13:0]        req_sort_key,
   input  logic [31:0]        req_payload,
   input  logic [5:0]         req_node_sel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_match_count,
   output logic signed [6:0]  rsp_node_index,
   output logic [63:0]        rsp_read_key,
   output logic signed [14:0] rsp_read_sort_key,
   output logic [31:0]        rsp_read_payload,
   output logic signed [6:0]  rsp_read_link,
   output logic signed [6:0]  rsp_list_head,
   output logic signed [6:0]  rsp_free_top
);
   clfl_pkg::dp_status_type stat;
   clfl_pkg::op_type        op;

   // sequence the walks; hold the response until the receiver frees it
   clfl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .op(op)
   );

   // node stores, heads and result registers
   clfl_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock(clock), .reset(reset), .op(op), .stat(stat),
      .req_action(req_action), .req_list_sel(req_list_sel),
      .req_dest_list(req_dest_list), .req_match_key(req_match_key),
      .req_sort_key(req_sort_key), .req_payload(req_payload),
      .req_node_sel(req_node_sel),
      .rsp_status(rsp_status), .rsp_match_count(rsp_match_count),
      .rsp_node_index(rsp_node_index), .rsp_read_key(rsp_read_key),
      .rsp_read_sort_key(rsp_read_sort_key), .rsp_read_payload(rsp_read_payload),
      .rsp_read_link(rsp_read_link), .rsp_list_head(rsp_list_head),
      .rsp_free_top(rsp_free_top)
   );

`ifndef ASSERT_OFF
   // one request in flight: an accepted beat closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // a node index is only reported by a successful insert
   a_node_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_node_index != -7'sd1) |-> (rsp_status == clfl_pkg::ST_OK))
      else $error("node index reported with failing status");

   // a rejected request reports no count and no read data
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == clfl_pkg::ST_BAD) |->
      (rsp_match_count == 7'd0 && rsp_read_link == 7'sd0 && rsp_read_sort_key == 15'sd0))
      else $error("rejected request carries data");
`endif
endmodule

// ===== verif/cursor_list_with_free_list_tb.sv =====
// Self-checking testbench for the cursor list with free list block.
`timescale 1ns / 1ps
module cursor_list_with_free_list_tb;

   localparam int NODES      = 64;
   localparam int RAND_BEATS = 930;
   localparam int IDLE_LIMIT = 200000;
   // action codes the block must reject
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]  act;
      logic        lsel;
      logic        dsel;
      logic [63:0] key;
      logic [13:0] id;
      logic [31:0] pay;
      logic [5:0]  sel;
   } req_beat_type;

   typedef struct {
      logic [1:0]         status;
      logic [6:0]         count;
      logic signed [6:0]  node;
      logic [63:0]        rkey;
      logic signed [14:0] rid;
      logic [31:0]        rpay;
      logic signed [6:0]  rlink;
      logic signed [6:0]  head;
      logic signed [6:0]  ftop;
   } rsp_beat_type;

   // Holds a mirror of the node store and the queue of expected responses.
   class list_scoreboard;
      int           nlink[NODES];
      logic [63:0]  nkey[NODES];
      int           nid[NODES];
      logic [31:0]  npay[NODES];
      bit           written[NODES];
      int           lhead[2];
      int           ftop;
      rsp_beat_type expected_q[$];
      int           fails;

      function new();
         for (int i = 0; i < NODES; i++) begin
            nlink[i] = i - 1;
            nid[i] = clfl_pkg::NO_ID;
            written[i] = 0;
         end
         lhead[0] = -1;
         lhead[1] = -1;
         ftop = NODES - 1;
         fails = 0;
      endfunction

      function int take();
         int n;
         n = ftop;
         if (n < 0 || n >= NODES) return -1;
         ftop = nlink[n];
         nlink[n] = -2;
         return n;
      endfunction

      function void relink(int l, int prev, int target);
         if (prev < 0) lhead[l] = target;
         else nlink[prev] = target;
      endfunction

      function int unlink_matches(int l, logic [63:0] k, bit every);
         int prev, cur, nxt, cnt, steps;
         prev = -1; cur = lhead[l]; cnt = 0; steps = 0;
         while (cur >= 0 && cur < NODES && steps < NODES) begin
            nxt = nlink[cur];
            steps++;
            if (nkey[cur] == k) begin
               relink(l, prev, nxt);
               nlink[cur] = ftop;
               ftop = cur;
               cnt++;
               if (!every) break;
            end else prev = cur;
            cur = nxt;
         end
         return cnt;
      endfunction

      function int list_len(int l);
         int cur, n;
         cur = lhead[l]; n = 0;
         while (cur >= 0 && cur < NODES && n < NODES) begin
            cur = nlink[cur];
            n++;
         end
         return n;
      endfunction

      // Work out the response to an accepted request beat.
      function void note(req_beat_type r);
         rsp_beat_type e;
         int l, d, node, cnt, cur, prev, p, outer, inner, n;
         bit skipped;
         l = r.lsel; d = r.dsel;
         e.status = clfl_pkg::ST_OK; e.count = 0; e.rkey = 0; e.rid = 0; e.rpay = 0;
         e.rlink = 0;
         node = -1; cnt = 0;
         case (r.act)
            clfl_pkg::ACT_INSERT: begin
               node = take();
               if (node < 0) e.status = clfl_pkg::ST_HEAP_FULL;
               else begin
                  nkey[node] = r.key; nid[node] = r.id; npay[node] = r.pay;
                  written[node] = 1;
                  nlink[node] = lhead[l];
                  lhead[l] = node;
               end
            end
            clfl_pkg::ACT_DEL_FIRST:
               if (unlink_matches(l, r.key, 0) == 0) e.status = clfl_pkg::ST_NOT_FOUND;
            clfl_pkg::ACT_DEL_ALL: cnt = unlink_matches(l, r.key, 1);
            clfl_pkg::ACT_COPY: begin
               if (l == d) e.status = clfl_pkg::ST_BAD;
               else begin
                  skipped = 0; cur = lhead[l]; outer = 0;
                  while (cur >= 0 && cur < NODES && outer < NODES) begin
                     prev = -1; p = lhead[d]; inner = 0;
                     outer++;
                     while (p >= 0 && p < NODES && inner < NODES && nid[p] < nid[cur]) begin
                        prev = p; p = nlink[p]; inner++;
                     end
                     n = take();
                     if (n < 0) skipped = 1;
                     else begin
                        nlink[n] = p;
                        nkey[n] = nkey[cur]; nid[n] = nid[cur]; npay[n] = npay[cur];
                        written[n] = 1;
                        relink(d, prev, n);
                        cnt++;
                     end
                     cur = nlink[cur];
                  end
                  if (skipped) e.status = clfl_pkg::ST_HEAP_FULL;
               end
            end
            clfl_pkg::ACT_READ: begin
               e.rkey = nkey[r.sel]; e.rid = 15'(nid[r.sel]);
               e.rpay = npay[r.sel]; e.rlink = 7'(nlink[r.sel]);
            end
            clfl_pkg::ACT_CLEAR: lhead[l] = -1;
            default: e.status = clfl_pkg::ST_BAD;
         endcase
         e.count = 7'(cnt);
         e.node = 7'(node);
         e.head = 7'(lhead[l]);
         e.ftop = 7'(ftop);
         expected_q.push_back(e);
      endfunction

      function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fails++;
         end
      endfunction

      function void check(rsp_beat_type a);
         rsp_beat_type e;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing expected");
            fails++;
            return;
         end
         e = expected_q.pop_front();
         cmp("status", e.status, a.status);
         cmp("match_count", e.count, a.count);
         cmp("node_index", 7'(e.node), 7'(a.node));
         cmp("read_key", e.rkey, a.rkey);
         cmp("read_sort_key", 15'(e.rid), 15'(a.rid));
         cmp("read_payload", e.rpay, a.rpay);
         cmp("read_link", 7'(e.rlink), 7'(a.rlink));
         cmp("list_head", 7'(e.head), 7'(a.head));
         cmp("free_top", 7'(e.ftop), 7'(a.ftop));
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_action;
   logic req_list_sel, req_dest_list;
   logic [63:0] req_match_key;
   logic [13:0] req_sort_key;
   logic [31:0] req_payload;
   logic [5:0] req_node_sel;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   logic [6:0] rsp_match_count;
   logic signed [6:0] rsp_node_index, rsp_read_link, rsp_list_head, rsp_free_top;
   logic [63:0] rsp_read_key;
   logic signed [14:0] rsp_read_sort_key;
   logic [31:0] rsp_read_payload;

   cursor_list_with_free_list dut (.*);

   list_scoreboard sb = new();
   int tx_idle_pct;   // chance the sender holds off a cycle
   int rx_idle_pct;   // chance the receiver stalls a cycle
   int quiet_cycles;
   logic [63:0] key_pool[4];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Receiver: stall at random and check every accepted response beat.
   always @(posedge clock) begin
      rsp_beat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status; got.count = rsp_match_count;
         got.node = rsp_node_index; got.rkey = rsp_read_key;
         got.rid = rsp_read_sort_key; got.rpay = rsp_read_payload;
         got.rlink = rsp_read_link; got.head = rsp_list_head; got.ftop = rsp_free_top;
         sb.check(got);
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Watchdog: end the run when neither channel has moved a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("cursor_list_with_free_list verification failed");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // Present one request beat, hold it until taken, then note it.
   task automatic send(req_beat_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= r.act; req_list_sel <= r.lsel; req_dest_list <= r.dsel;
      req_match_key <= r.key; req_sort_key <= r.id; req_payload <= r.pay;
      req_node_sel <= r.sel;
      do @(posedge clock); while (req_stall);
      sb.note(r);
   endtask

   task automatic send_op(logic [2:0] act, logic lsel, logic dsel, logic [63:0] key,
                          logic [13:0] id, logic [31:0] pay, logic [5:0] sel);
      req_beat_type r;
      r.act = act; r.lsel = lsel; r.dsel = dsel; r.key = key;
      r.id = id; r.pay = pay; r.sel = sel;
      send(r);
   endtask

   // Build a random beat; reads only ever target nodes that hold data.
   function automatic req_beat_type rand_beat(bit allow_clear);
      req_beat_type r;
      int pick, node;
      r.lsel = 1'($urandom_range(1)); r.dsel = 1'($urandom_range(1));
      r.key = ($urandom_range(99) < 70) ? key_pool[$urandom_range(3)] : {$urandom, $urandom};
      r.id = ($urandom_range(1)) ? 14'($urandom_range(7)) : 14'($urandom);
      r.pay = $urandom; r.sel = 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 32) r.act = clfl_pkg::ACT_INSERT;
      else if (pick < 52) r.act = clfl_pkg::ACT_DEL_FIRST;
      else if (pick < 66) r.act = clfl_pkg::ACT_DEL_ALL;
      else if (pick < 74) r.act = clfl_pkg::ACT_COPY;
      else if (pick < 94) r.act = clfl_pkg::ACT_READ;
      else if (pick < 96) r.act = pick[0] ? ACT_SPARE_LO : ACT_SPARE_HI;
      else r.act = (allow_clear || sb.list_len(r.lsel) == 0) ? clfl_pkg::ACT_CLEAR
                                                             : clfl_pkg::ACT_INSERT;
      if (r.act == clfl_pkg::ACT_READ) begin
         node = $urandom_range(NODES - 1);
         for (int k = 0; k < NODES && !sb.written[node]; k++) node = (node + 1) % NODES;
         if (sb.written[node]) r.sel = 6'(node);
         else r.act = clfl_pkg::ACT_INSERT;
      end
      return r;
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_action = clfl_pkg::ACT_INSERT; req_list_sel = 1'b0;
      req_dest_list = 1'b0;
      req_match_key = '0; req_sort_key = '0; req_payload = '0; req_node_sel = '0;
      tx_idle_pct = 12; rx_idle_pct = 53;
      key_pool[0] = 64'h0; key_pool[1] = '1;
      key_pool[2] = {$urandom, $urandom}; key_pool[3] = {$urandom, $urandom};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every action, rejected and empty cases.
      send_op(clfl_pkg::ACT_INSERT, 0, 0, '1, 14'h3FFF, '1, 0);
      send_op(clfl_pkg::ACT_INSERT, 1, 0, '0, 0, '0, '1);
      send_op(clfl_pkg::ACT_INSERT, 1, 0, key_pool[2], 5, 32'h5A5A_A5A5, 0);
      send_op(clfl_pkg::ACT_INSERT, 1, 0, '1, 5, 32'h1234_5678, 0);
      send_op(clfl_pkg::ACT_READ, 0, 0, 0, 0, 0, 6'd63);
      send_op(clfl_pkg::ACT_READ, 0, 0, 0, 0, 0, 6'd62);
      send_op(clfl_pkg::ACT_DEL_FIRST, 0, 0, key_pool[3], 0, 0, 0);
      send_op(clfl_pkg::ACT_COPY, 1, 1, 0, 0, 0, 0);
      send_op(clfl_pkg::ACT_COPY, 1, 0, 0, 0, 0, 0);
      send_op(clfl_pkg::ACT_INSERT, 0, 0, key_pool[2], 5, 32'h0F0F_0F0F, 0);
      send_op(clfl_pkg::ACT_COPY, 0, 1, 0, 0, 0, 0);
      send_op(clfl_pkg::ACT_DEL_ALL, 0, 0, '1, 0, 0, 0);
      send_op(clfl_pkg::ACT_DEL_ALL, 1, 0, key_pool[3], 0, 0, 0);
      send_op(ACT_SPARE_LO, 0, 1, 0, 0, 0, 0);
      send_op(ACT_SPARE_HI, 1, 0, 0, 0, 0, 0);
      send_op(clfl_pkg::ACT_DEL_FIRST, 1, 0, key_pool[2], 0, 0, 0);
      send_op(clfl_pkg::ACT_READ, 1, 0, 0, 0, 0, 6'd60);
      send_op(clfl_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
      send_op(clfl_pkg::ACT_READ, 0, 0, 0, 0, 0, 6'd61);

      // Random: three idling regimes; clears of non-empty lists only near the end, as they leak nodes.
      for (int i = 0; i < RAND_BEATS; i++) begin
         if (i == RAND_BEATS / 3) begin
            tx_idle_pct = 53; rx_idle_pct = 12;
         end else if (i == 2 * RAND_BEATS / 3) begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         send(rand_beat(i > RAND_BEATS - 100));
      end
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.fails == 0) $display("cursor_list_with_free_list verification clean");
      else $display("cursor_list_with_free_list verification failed");
      $finish;
   end
endmodule

// ===== cursor_list_with_free_list.f =====
rtl/clfl_pkg.sv
rtl/clfl_ram.sv
rtl/clfl_ctrl.sv
rtl/clfl_dp.sv
rtl/cursor_list_with_free_list.sv
verif/cursor_list_with_free_list_tb.sv
